// ===== sv/ire_pkg.sv =====
package ire_pkg;

  localparam int TokenCount = 13;
  localparam logic [15:0] MaxValue = 16'd3999;

  typedef logic [3:0] token_idx_t;
  typedef logic [6:0] char_t;
  typedef logic [11:0] rem_t;

  localparam char_t CharNone = 7'h00;
  localparam char_t CharI = 7'h49;
  localparam char_t CharV = 7'h56;
  localparam char_t CharX = 7'h58;
  localparam char_t CharL = 7'h4C;
  localparam char_t CharC = 7'h43;
  localparam char_t CharD = 7'h44;
  localparam char_t CharM = 7'h4D;

  // One queued job: the classified value as handed from front to back.
  typedef struct packed {
    logic error;
    rem_t value;
  } ire_job_t;

  function automatic rem_t tok_value(input token_idx_t idx);
    rem_t v;
    unique case (idx)
      4'd0: v = 12'd1000;
      4'd1: v = 12'd900;
      4'd2: v = 12'd500;
      4'd3: v = 12'd400;
      4'd4: v = 12'd100;
      4'd5: v = 12'd90;
      4'd6: v = 12'd50;
      4'd7: v = 12'd40;
      4'd8: v = 12'd10;
      4'd9: v = 12'd9;
      4'd10: v = 12'd5;
      4'd11: v = 12'd4;
      default: v = 12'd1;
    endcase
    return v;
  endfunction

  function automatic char_t tok_first(input token_idx_t idx);
    char_t c;
    unique case (idx)
      4'd0: c = CharM;
      4'd1: c = CharC;
      4'd2: c = CharD;
      4'd3: c = CharC;
      4'd4: c = CharC;
      4'd5: c = CharX;
      4'd6: c = CharL;
      4'd7: c = CharX;
      4'd8: c = CharX;
      4'd9: c = CharI;
      4'd10: c = CharV;
      4'd11: c = CharI;
      default: c = CharI;
    endcase
    return c;
  endfunction

  // CharNone marks a one-letter token.
  function automatic char_t tok_second(input token_idx_t idx);
    char_t c;
    unique case (idx)
      4'd1: c = CharM;
      4'd3: c = CharD;
      4'd5: c = CharC;
      4'd7: c = CharL;
      4'd9: c = CharX;
      4'd11: c = CharV;
      default: c = CharNone;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/ire_value_if.sv =====
interface ire_value_if;
  logic valid;
  logic ready;
  logic [15:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// ===== sv/ire_letter_if.sv =====
interface ire_letter_if;
  logic valid;
  logic ready;
  logic [6:0] letter;
  logic last;
  logic error;

  modport source (output valid, output letter, output last, output error, input ready);
  modport sink (input valid, input letter, input last, input error, output ready);
endinterface

// ===== sv/ire_front.sv =====
module ire_front
  import ire_pkg::*;
(
  ire_value_if.sink item,
  input  logic      full,
  output logic      push,
  output ire_job_t  job
);

  always_comb begin
    item.ready = !full;
    push = item.valid && !full;
    job.error = (item.value == 16'd0) || (item.value > MaxValue);
    job.value = item.value[11:0];
  end

endmodule

// ===== sv/ire_queue.sv =====
module ire_queue
  import ire_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  ire_job_t push_job,
  output logic     full,
  input  logic     pop,
  output logic     avail,
  output ire_job_t head
);

  ire_job_t entries [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  always_comb begin
    full = count[1];
    avail = count != 2'd0;
    head = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== sv/ire_back.sv =====
module ire_back
  import ire_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      avail,
  input  ire_job_t  head,
  output logic      pop,
  ire_letter_if.source result
);

  logic busy;
  logic busy_next;
  rem_t remaining;
  rem_t remaining_next;
  logic pending;
  logic pending_next;
  char_t pending_char;
  char_t pending_char_next;

  logic out_valid;
  char_t out_letter;
  logic out_last;
  logic out_error;

  logic out_load;
  logic advance;
  rem_t cur_rem;
  token_idx_t sel;
  rem_t diff;
  char_t second;
  char_t step_letter;
  logic step_last;
  logic step_error;

  // Largest token that still fits; the compares are independent of each other.
  always_comb begin
    cur_rem = busy ? remaining : head.value;
    sel = token_idx_t'(TokenCount - 1);
    for (int i = TokenCount - 1; i >= 0; i--) begin
      if (cur_rem >= tok_value(token_idx_t'(i))) begin
        sel = token_idx_t'(i);
      end
    end
    diff = cur_rem - tok_value(sel);
    second = tok_second(sel);
  end

  always_comb begin
    out_load = !out_valid || result.ready;
    advance = out_load && (busy || avail);
    pop = out_load && !busy && avail;

    busy_next = busy;
    remaining_next = remaining;
    pending_next = pending;
    pending_char_next = pending_char;
    step_letter = CharNone;
    step_last = 1'b1;
    step_error = 1'b0;

    if (advance) begin
      if (!busy && head.error) begin
        step_error = 1'b1;
      end else if (busy && pending) begin
        step_letter = pending_char;
        step_last = remaining == 12'd0;
        pending_next = 1'b0;
        busy_next = !step_last;
      end else begin
        step_letter = tok_first(sel);
        remaining_next = diff;
        pending_next = second != CharNone;
        pending_char_next = second;
        step_last = (second == CharNone) && (diff == 12'd0);
        busy_next = !step_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pending <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      busy <= busy_next;
      pending <= pending_next;
      if (out_load) begin
        out_valid <= advance;
      end
    end
  end

  always_ff @(posedge clk) begin
    remaining <= remaining_next;
    pending_char <= pending_char_next;
    if (advance) begin
      out_letter <= step_letter;
      out_last <= step_last;
      out_error <= step_error;
    end
  end

  always_comb begin
    result.valid = out_valid;
    result.letter = out_letter;
    result.last = out_last;
    result.error = out_error;
  end

endmodule

// ===== sv/integer_to_roman_encoder_unit.sv =====
// Converts each accepted 16-bit value to its Roman numeral, one ASCII letter
// per result beat in writing order, with last set on the final letter; a value
// of 0 or above 3999 gives one beat with letter 0, last and error set. The
// front classifies a value in the cycle it is accepted and places it in a
// two-entry queue, so new values are taken while the back is still emitting.
// The back sequencer produces one letter per cycle while the sink takes them,
// and a numeral has 1 to 15 letters (15 for 3888); an error gives a single
// beat. The output register holds a beat while the sink stalls, and the back
// pauses with it.
module integer_to_roman_encoder_unit
  import ire_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ire_value_if.sink item,
  ire_letter_if.source result
);

  logic push;
  logic full;
  logic pop;
  logic avail;
  ire_job_t push_job;
  ire_job_t head;

  ire_front u_front (
    .item (item),
    .full (full),
    .push (push),
    .job  (push_job)
  );

  ire_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .avail    (avail),
    .head     (head)
  );

  ire_back u_back (
    .clk    (clk),
    .rst    (rst),
    .avail  (avail),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule
